@@ hdl/drfe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drfe_pkg
// shared types, register codes and reset values of the field extractor
// ----------------------------------------------------------------------------
package drfe_pkg;

  localparam int SEP_MAX_DEF         = 4;
  localparam int FIELD_INDEX_MAX_DEF = 255;

  // separator registers hold at most four bytes
  localparam int SEP_HW_LIM = 4;
  localparam int LEN_W      = 3;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  localparam logic [31:0]      FS_RST     = 32'd9;
  localparam logic [LEN_W-1:0] FS_LEN_RST = 3'd1;
  localparam logic [31:0]      RS_RST     = 32'd10;
  localparam logic [LEN_W-1:0] RS_LEN_RST = 3'd1;
  localparam logic [7:0]       WANTED_RST = 8'd0;

  typedef enum logic [2:0] {
    REG_FS     = 3'd0,
    REG_FS_LEN = 3'd1,
    REG_RS     = 3'd2,
    REG_RS_LEN = 3'd3,
    REG_WANTED = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [31:0]      fs;
    logic [LEN_W-1:0] fs_len;
    logic [31:0]      rs;
    logic [LEN_W-1:0] rs_len;
    logic [7:0]       wanted;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       field_end;
    logic       record_end;
    logic       field_found;
    logic       partial_dropped;
  } result_t;

endpackage

@@ hdl/drfe_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drfe_cfg_regs
// apb register file for separators, their lengths and the wanted field
// ----------------------------------------------------------------------------
module drfe_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [drfe_pkg::ADDR_W-1:0]   paddr,
  input  logic [drfe_pkg::DATA_W-1:0]   pwdata,
  output logic [drfe_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output drfe_pkg::cfg_t                cfg
);
  import drfe_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_FS:     cfg_nxt.fs     = pwdata;
        REG_FS_LEN: cfg_nxt.fs_len = pwdata[LEN_W-1:0];
        REG_RS:     cfg_nxt.rs     = pwdata;
        REG_RS_LEN: cfg_nxt.rs_len = pwdata[LEN_W-1:0];
        REG_WANTED: cfg_nxt.wanted = pwdata[7:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FS:     prdata = cfg_r.fs;
      REG_FS_LEN: prdata = {{(DATA_W-LEN_W){1'b0}}, cfg_r.fs_len};
      REG_RS:     prdata = cfg_r.rs;
      REG_RS_LEN: prdata = {{(DATA_W-LEN_W){1'b0}}, cfg_r.rs_len};
      REG_WANTED: prdata = {{(DATA_W-8){1'b0}}, cfg_r.wanted};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fs     <= FS_RST;
      cfg_r.fs_len <= FS_LEN_RST;
      cfg_r.rs     <= RS_RST;
      cfg_r.rs_len <= RS_LEN_RST;
      cfg_r.wanted <= WANTED_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ hdl/drfe_parse.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drfe_parse
// pending window, separator match and record state, one byte per beat
// ----------------------------------------------------------------------------
module drfe_parse #(
  parameter int SEP_MAX         = drfe_pkg::SEP_MAX_DEF,
  parameter int FIELD_INDEX_MAX = drfe_pkg::FIELD_INDEX_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  drfe_pkg::cfg_t    cfg,
  input  logic              fire,
  input  logic [7:0]        in_byte,
  input  logic              eos,
  output drfe_pkg::result_t res,
  output logic              res_vld
);
  import drfe_pkg::*;

  localparam int SEP_LIM = (SEP_MAX < SEP_HW_LIM) ? SEP_MAX : SEP_HW_LIM;
  localparam int CNT_W   = $clog2(SEP_MAX + 1);
  localparam int MW      = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int FC_W    = $clog2(FIELD_INDEX_MAX + 1);
  localparam int CMP_W   = (FC_W > 8) ? FC_W : 8;
  localparam int EXT_N   = SEP_MAX + SEP_HW_LIM;

  logic [7:0]       win_r   [SEP_MAX];
  logic [7:0]       win_nxt [SEP_MAX];
  logic [7:0]       win_ext [EXT_N];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [FC_W-1:0]  fc_r, fc_nxt;
  logic             sel_done_r, sel_done_nxt;
  logic             rhb_r, rhb_nxt;

  logic [MW-1:0]    fs_len, rs_len, need, cnt_app, drop;
  logic             fs_hit, rs_hit, decide, idx_eq, in_wanted;

  // length 0 acts as 1, anything above the window limit is clamped
  function automatic logic [MW-1:0] eff_len(input logic [LEN_W-1:0] v);
    logic [MW-1:0] r;
    r = MW'(v);
    if (v == '0) begin
      r = MW'(1);
    end else if (MW'(v) > MW'(SEP_LIM)) begin
      r = MW'(SEP_LIM);
    end
    return r;
  endfunction

  always_comb begin
    fs_len = eff_len(cfg.fs_len);
    rs_len = eff_len(cfg.rs_len);
    need   = (fs_len > rs_len) ? fs_len : rs_len;

    // append the new byte behind the pending ones
    for (int k = 0; k < EXT_N; k++) begin
      win_ext[k] = '0;
    end
    for (int k = 0; k < SEP_MAX; k++) begin
      win_ext[k] = win_r[k];
    end
    cnt_app = MW'(cnt_r);
    if (cnt_r < CNT_W'(SEP_MAX)) begin
      for (int k = 0; k < SEP_MAX; k++) begin
        if (CNT_W'(k) == cnt_r) begin
          win_ext[k] = in_byte;
        end
      end
      cnt_app = MW'(cnt_r) + MW'(1);
    end

    fs_hit = (fs_len <= cnt_app);
    rs_hit = (rs_len <= cnt_app);
    for (int k = 0; k < SEP_LIM; k++) begin
      if (MW'(k) < fs_len && win_ext[k] != cfg.fs[8*k +: 8]) begin
        fs_hit = 1'b0;
      end
      if (MW'(k) < rs_len && win_ext[k] != cfg.rs[8*k +: 8]) begin
        rs_hit = 1'b0;
      end
    end
    decide = (cnt_app >= need);

    idx_eq    = (CMP_W'(fc_r) == CMP_W'(cfg.wanted));
    in_wanted = idx_eq && !sel_done_r;

    fc_nxt       = fc_r;
    sel_done_nxt = sel_done_r;
    rhb_nxt      = rhb_r;
    drop         = '0;
    res          = '0;
    res_vld      = 1'b0;

    if (eos) begin
      // whole record state back to reset, pending bytes discarded
      fc_nxt              = '0;
      sel_done_nxt        = 1'b0;
      rhb_nxt             = 1'b0;
      res_vld             = rhb_r || (cnt_r != '0);
      res.partial_dropped = res_vld;
    end else if (decide) begin
      if (fs_hit) begin
        drop    = fs_len;
        rhb_nxt = 1'b1;
        if (fc_r < FC_W'(FIELD_INDEX_MAX)) begin
          fc_nxt = fc_r + FC_W'(1);
        end
        if (in_wanted) begin
          sel_done_nxt  = 1'b1;
          res.field_end = 1'b1;
          res_vld       = 1'b1;
        end
      end else if (rs_hit) begin
        drop            = rs_len;
        res.field_end   = in_wanted;
        res.record_end  = 1'b1;
        res.field_found = sel_done_r || idx_eq;
        res_vld         = 1'b1;
        fc_nxt          = '0;
        sel_done_nxt    = 1'b0;
        rhb_nxt         = 1'b0;
      end else begin
        drop    = MW'(1);
        rhb_nxt = 1'b1;
        if (in_wanted) begin
          res.data       = win_ext[0];
          res.byte_valid = 1'b1;
          res_vld        = 1'b1;
        end
      end
    end

    // shift out the decided bytes
    for (int k = 0; k < SEP_MAX; k++) begin
      win_nxt[k] = win_ext[k];
      for (int m = 1; m <= SEP_HW_LIM; m++) begin
        if (drop == MW'(m)) begin
          win_nxt[k] = win_ext[k+m];
        end
      end
    end
    cnt_nxt = eos ? '0 : CNT_W'(cnt_app - drop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      fc_r       <= '0;
      sel_done_r <= 1'b0;
      rhb_r      <= 1'b0;
    end else if (fire) begin
      cnt_r      <= cnt_nxt;
      fc_r       <= fc_nxt;
      sel_done_r <= sel_done_nxt;
      rhb_r      <= rhb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      win_r <= win_nxt;
    end
  end

  // every beat that decides frees at least one slot, so the window never fills up
  a_cnt_room: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < CNT_W'(SEP_MAX))
    else $error("pending window overfilled");

  a_eos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && eos) |=> (cnt_r == '0 && fc_r == '0 && !sel_done_r && !rhb_r))
    else $error("record state not cleared at end of stream");

  a_res_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res_vld) |-> $onehot0({res.byte_valid, res.record_end, res.partial_dropped}))
    else $error("result mixes byte, record end and drop");

endmodule

@@ hdl/drfe_out_buf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drfe_out_buf
// output register with one skid entry that catches a result pushed under back-pressure
// ----------------------------------------------------------------------------
module drfe_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  drfe_pkg::result_t push_data,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output drfe_pkg::result_t out_data
);
  import drfe_pkg::*;

  result_t out_r, skid_r;
  logic    out_vld_r, skid_vld_r;
  logic    pop;

  assign pop       = out_vld_r & out_ready;
  assign space     = ~skid_vld_r;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (pop) begin
        skid_vld_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_vld_r || pop) begin
        out_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (pop) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (push) begin
      if (!out_vld_r || pop) begin
        out_r <= push_data;
      end else begin
        skid_r <= push_data;
      end
    end
  end

  a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry held with output register empty");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (push && out_vld_r && !out_ready) |=> skid_vld_r)
    else $error("result pushed into stalled output was lost");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_vld_r)
    else $error("push while both entries are full");

endmodule

@@ hdl/delimited_record_field_extractor_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_record_field_extractor_core
// splits a byte stream into records and fields, forwards one chosen field
// ----------------------------------------------------------------------------
// a result beat is registered in the output register, or in the skid entry under
// back-pressure, before it shows on out_*; one input beat per cycle while
// in_tready is high, set by the window and record state update in the parse stage
// in_tready drops only while the output register and its skid entry both hold
// results; reset is synchronous, empties the pending window, clears record
// state and loads the register defaults (tab FS, newline RS, field 0)
// ----------------------------------------------------------------------------
module delimited_record_field_extractor_core #(
  parameter int SEP_MAX         = drfe_pkg::SEP_MAX_DEF,
  parameter int FIELD_INDEX_MAX = drfe_pkg::FIELD_INDEX_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] in_byte
  input  logic                        in_tlast,   // end_of_stream
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,  // [7:0] out_byte
  output logic                        out_tlast,  // record_end
  output logic [3:0]                  out_tuser,  // [0] byte_valid, [1] field_end,
                                                  // [2] field_found, [3] partial_dropped
  // configuration
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [drfe_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [drfe_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [drfe_pkg::DATA_W-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import drfe_pkg::*;

  cfg_t    cfg;
  result_t res;
  result_t out_data;
  logic    res_vld;
  logic    in_fire;
  logic    space;

  // a beat enters whenever the skid entry is free
  assign in_tready = space;
  assign in_fire   = in_tvalid & in_tready;

  drfe_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // window append, separator compare and record bookkeeping
  drfe_parse #(
    .SEP_MAX         (SEP_MAX),
    .FIELD_INDEX_MAX (FIELD_INDEX_MAX)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .fire    (in_fire),
    .in_byte (in_tdata),
    .eos     (in_tlast),
    .res     (res),
    .res_vld (res_vld)
  );

  // only beats that produce a result are queued
  drfe_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire & res_vld),
    .push_data (res),
    .space     (space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_data)
  );

  assign out_tdata = out_data.data;
  assign out_tlast = out_data.record_end;
  assign out_tuser = {out_data.partial_dropped, out_data.field_found,
                      out_data.field_end, out_data.byte_valid};

endmodule
